/* rtl/csd_pkg.sv */
package csd_pkg;

  // One character of the search window, wide enough for 16-bit text.
  typedef logic [15:0] char_t;

  // Number of pattern characters that the registers can hold.
  localparam int unsigned PATTERN_SLOTS = 16;

  // Byte-order mark of little-endian 16-bit text, in arrival order.
  localparam logic [7:0] MARK_FIRST  = 8'hFF;
  localparam logic [7:0] MARK_SECOND = 8'hFE;

  // Case folding of the letters A to Z.
  localparam char_t UPPER_A     = 16'h0041;
  localparam char_t UPPER_Z     = 16'h005A;
  localparam char_t CASE_OFFSET = 16'd32;

  // Progress through the head of a file.
  typedef enum logic [2:0] {
    HEAD_FIRST  = 3'b001,
    HEAD_SECOND = 3'b010,
    HEAD_BODY   = 3'b100
  } head_e;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_NARROW_LEN = 3'd0,
    REG_NARROW_LO  = 3'd1,
    REG_NARROW_HI  = 3'd2,
    REG_WIDE_LEN   = 3'd3,
    REG_WIDE_0     = 3'd4,
    REG_WIDE_1     = 3'd5,
    REG_WIDE_2     = 3'd6,
    REG_WIDE_3     = 3'd7
  } cfg_reg_e;

  // Shift control that runs along the row of window cells.
  typedef struct packed {
    logic shift_one;
    logic shift_two;
  } cell_ctrl_t;

  // Folds an upper-case letter to lower case and leaves anything else alone.
  function automatic char_t fold_char(input char_t c);
    fold_char = ((c >= UPPER_A) && (c <= UPPER_Z)) ? (c + CASE_OFFSET) : c;
  endfunction

endpackage

/* rtl/caseless_substring_detector.sv */
// Accepts one file byte per clock cycle, back to back, while the input is not stalled.
// The result of a file is loaded into the output register when its last byte
// is accepted; the window compare of all cells is combinational.
// Input stall rises only while a result is held and the output is stalled.
// Reset is asynchronous and active low; it clears the registers, the per-file
// state and the output valid. No clearing pass is needed after reset.
module caseless_substring_detector import csd_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        text_found_o,
  output logic        was_wide_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW     = $clog2(MAX_PATTERN + 1);
  localparam logic [CntW-1:0] SEEN_MAX = CntW'(MAX_PATTERN);
  localparam logic [CntW-1:0] SEEN_TWO = CntW'((MAX_PATTERN >= 2) ? 2 : 1);

  // Configuration registers.
  logic [4:0]  narrow_len_q, wide_len_q;
  logic [63:0] narrow_lo_q, narrow_hi_q;
  logic [63:0] wide_pat_q [4];

  // Per-file state.
  head_e           head_q, head_d;
  logic [7:0]      first_q, first_d;
  logic            wide_q, wide_d;
  logic            phase_q, phase_d;
  logic [7:0]      low_q, low_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic            found_q, found_d;

  // Output register.
  logic out_valid_q, text_found_q, was_wide_q;

  logic       in_accept, cfg_write;
  logic       feed, head_hit, len_ok, hit;
  char_t      feed_a, feed_b;
  cell_ctrl_t ctrl;
  logic [4:0] cur_len;

  char_t pat_chars [PATTERN_SLOTS];
  char_t chain [MAX_PATTERN + 2];
  logic [MAX_PATTERN-1:0] match;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // Register writes; the length registers keep five bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_len_q <= '0;
      narrow_lo_q  <= '0;
      narrow_hi_q  <= '0;
      wide_len_q   <= '0;
      for (int r = 0; r < 4; r++) begin
        wide_pat_q[r] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(paddr[5:3]))
        REG_NARROW_LEN: narrow_len_q  <= pwdata[4:0];
        REG_NARROW_LO:  narrow_lo_q   <= pwdata;
        REG_NARROW_HI:  narrow_hi_q   <= pwdata;
        REG_WIDE_LEN:   wide_len_q    <= pwdata[4:0];
        REG_WIDE_0:     wide_pat_q[0] <= pwdata;
        REG_WIDE_1:     wide_pat_q[1] <= pwdata;
        REG_WIDE_2:     wide_pat_q[2] <= pwdata;
        REG_WIDE_3:     wide_pat_q[3] <= pwdata;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_reg_e'(paddr[5:3]))
      REG_NARROW_LEN: prdata = {59'd0, narrow_len_q};
      REG_NARROW_LO:  prdata = narrow_lo_q;
      REG_NARROW_HI:  prdata = narrow_hi_q;
      REG_WIDE_LEN:   prdata = {59'd0, wide_len_q};
      REG_WIDE_0:     prdata = wide_pat_q[0];
      REG_WIDE_1:     prdata = wide_pat_q[1];
      REG_WIDE_2:     prdata = wide_pat_q[2];
      REG_WIDE_3:     prdata = wide_pat_q[3];
    endcase
  end

  // Pattern characters of the current mode, character 0 first.
  for (genvar k = 0; k < PATTERN_SLOTS; k++) begin : g_pat
    logic [7:0] narrow_char;
    if (k < 8) begin : g_lo
      assign narrow_char = narrow_lo_q[8*k +: 8];
    end else begin : g_hi
      assign narrow_char = narrow_hi_q[8*(k-8) +: 8];
    end
    assign pat_chars[k] = wide_q ? wide_pat_q[k/4][16*(k%4) +: 16] : {8'd0, narrow_char};
  end

  assign cur_len = wide_q ? wide_len_q : narrow_len_q;

  // Head decoding, byte pairing and the characters fed into the window.
  always_comb begin
    head_d   = head_q;
    first_d  = first_q;
    wide_d   = wide_q;
    phase_d  = phase_q;
    low_d    = low_q;
    feed     = 1'b0;
    ctrl     = '0;
    feed_a   = fold_char({8'd0, data_byte_i});
    feed_b   = fold_char({8'd0, data_byte_i});
    head_hit = 1'b0;
    seen_d   = seen_q;
    unique case (head_q)
      HEAD_FIRST: begin
        first_d = data_byte_i;
        head_d  = HEAD_SECOND;
        if (end_of_file_i) begin
          feed           = 1'b1;
          ctrl.shift_one = 1'b1;
        end
      end
      HEAD_SECOND: begin
        head_d = HEAD_BODY;
        if ((first_q == MARK_FIRST) && (data_byte_i == MARK_SECOND)) begin
          wide_d = 1'b1;
        end else begin
          // Both head bytes enter at once; the first gets its own compare.
          feed           = 1'b1;
          ctrl.shift_two = 1'b1;
          feed_a         = fold_char({8'd0, first_q});
          head_hit       = (narrow_len_q == 5'd1) && (feed_a == pat_chars[0]);
        end
      end
      HEAD_BODY: begin
        if (wide_q) begin
          if (!phase_q) begin
            low_d   = data_byte_i;
            phase_d = 1'b1;
          end else begin
            phase_d        = 1'b0;
            feed           = 1'b1;
            ctrl.shift_one = 1'b1;
            feed_a         = fold_char({data_byte_i, low_q});
          end
        end else begin
          feed           = 1'b1;
          ctrl.shift_one = 1'b1;
        end
      end
      default: begin
        head_d = HEAD_FIRST;
      end
    endcase
    if (!in_accept) begin
      ctrl = '0;
      feed = 1'b0;
    end
    if (feed) begin
      if (ctrl.shift_two) begin
        seen_d = SEEN_TWO;
      end else if (seen_q != SEEN_MAX) begin
        seen_d = seen_q + CntW'(1);
      end
    end
  end

  // Head of the chain: second fed character, then first, then the cells.
  assign chain[0] = feed_b;
  assign chain[1] = feed_a;

  // Row of window cells, newest character in cell 0.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic  active;
    char_t expect_char;
    if (i < PATTERN_SLOTS) begin : g_cmp
      logic [3:0] diff;
      assign active      = cur_len > 5'(i);
      assign diff        = 4'(cur_len - 5'(i) - 5'd1);
      assign expect_char = pat_chars[diff];
    end else begin : g_nocmp
      assign active      = 1'b0;
      assign expect_char = '0;
    end
    csd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_one_i (chain[i+1]),
      .prev_two_i (chain[i]),
      .active_i   (active),
      .expect_i   (expect_char),
      .char_o     (chain[i+2]),
      .match_o    (match[i])
    );
  end

  // A hit needs a usable length and enough characters seen.
  assign len_ok = (cur_len != 5'd0) && (32'(cur_len) <= MAX_PATTERN) &&
                  (cur_len <= 5'(PATTERN_SLOTS)) && (32'(cur_len) <= 32'(seen_d));
  assign hit     = feed && ((len_ok && (&match)) || head_hit);
  assign found_d = found_q || hit;

  // Per-file state, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= HEAD_FIRST;
      first_q <= '0;
      wide_q  <= 1'b0;
      phase_q <= 1'b0;
      low_q   <= '0;
      seen_q  <= '0;
      found_q <= 1'b0;
    end else if (in_accept) begin
      if (end_of_file_i) begin
        head_q  <= HEAD_FIRST;
        first_q <= '0;
        wide_q  <= 1'b0;
        phase_q <= 1'b0;
        low_q   <= '0;
        seen_q  <= '0;
        found_q <= 1'b0;
      end else begin
        head_q  <= head_d;
        first_q <= first_d;
        wide_q  <= wide_d;
        phase_q <= phase_d;
        low_q   <= low_d;
        seen_q  <= seen_d;
        found_q <= found_d;
      end
    end
  end

  // Output register holding one result transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && end_of_file_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && end_of_file_i) begin
      text_found_q <= found_d;
      was_wide_q   <= wide_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_found_o = text_found_q;
  assign was_wide_o   = was_wide_q;

endmodule

/* rtl/csd_cell.sv */
module csd_cell import csd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  char_t      prev_one_i,
  input  char_t      prev_two_i,
  input  logic       active_i,
  input  char_t      expect_i,
  output char_t      char_o,
  output logic       match_o
);

  char_t char_q, char_d;

  // The cell takes the character one or two places behind it, or holds.
  always_comb begin
    priority if (ctrl_i.shift_two) begin
      char_d = prev_two_i;
    end else if (ctrl_i.shift_one) begin
      char_d = prev_one_i;
    end else begin
      char_d = char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  // A cell beyond the pattern length never blocks a hit.
  assign match_o = !active_i || (char_d == expect_i);
  assign char_o  = char_q;

endmodule

/* rtl/csd_checker.sv */
module csd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       end_of_file_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       text_found_o,
  input logic       was_wide_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(text_found_o) && $stable(was_wide_o))
    else $error("stalled result transaction changed");

  // Input is only held back by a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // A fresh result follows the acceptance of a last byte.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !($past(out_valid_o) && $past(out_stall_i)) |->
      $past(in_valid_i && !in_stall_o && end_of_file_i))
    else $error("result transaction without a last byte");

endmodule

bind caseless_substring_detector csd_checker u_csd_checker (.*);

/* tb/tb_caseless_substring_detector.sv */
`timescale 1ns / 100ps

module tb_caseless_substring_detector import csd_pkg::*;;

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned ITEMS = 2000;
  localparam int unsigned PHASE_BYTES = 220;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD = 300;
  localparam char_t LOWER_A = 16'h0061;
  localparam char_t LOWER_Z = 16'h007A;

  typedef struct packed {
    logic text_found;
    logic was_wide;
  } verdict_t;

  typedef enum {FILE_NARROW, FILE_WIDE, FILE_NOISE, FILE_TINY} file_kind_e;
  typedef enum {PATTERN_LETTERS, PATTERN_RAW} pattern_style_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  // Tracks the search state of the current file and the verdicts still owed.
  class match_tracker;
    logic [4:0]  narrow_len;
    logic [4:0]  wide_len;
    logic [63:0] narrow_lo;
    logic [63:0] narrow_hi;
    logic [63:0] wide_pat [4];
    head_e       head;
    logic [7:0]  first_hold;
    logic [7:0]  low_hold;
    logic        wide;
    logic        odd_pair;
    logic        found;
    char_t       win [WINDOW_DEPTH];
    int unsigned seen;
    verdict_t    verdicts_due [$];
    int          errors;
    int          files_checked;
    int          wide_files;
    int          hit_files;

    function new();
      int i;
      narrow_len = '0;
      wide_len = '0;
      narrow_lo = '0;
      narrow_hi = '0;
      for (i = 0; i < 4; i++) wide_pat[i] = '0;
      errors = 0;
      files_checked = 0;
      wide_files = 0;
      hit_files = 0;
      clear_file();
    endfunction

    function void clear_file();
      int i;
      head = HEAD_FIRST;
      first_hold = '0;
      low_hold = '0;
      wide = 1'b0;
      odd_pair = 1'b0;
      found = 1'b0;
      seen = 0;
      for (i = 0; i < WINDOW_DEPTH; i++) win[i] = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] value);
      case (idx)
        REG_NARROW_LEN: narrow_len = value[4:0];
        REG_NARROW_LO:  narrow_lo = value;
        REG_NARROW_HI:  narrow_hi = value;
        REG_WIDE_LEN:   wide_len = value[4:0];
        REG_WIDE_0:     wide_pat[0] = value;
        REG_WIDE_1:     wide_pat[1] = value;
        REG_WIDE_2:     wide_pat[2] = value;
        REG_WIDE_3:     wide_pat[3] = value;
        default: ;
      endcase
    endfunction

    function char_t pattern_char(int unsigned k);
      logic [63:0] w;
      if (wide) begin
        w = wide_pat[k / 4];
        return w[16 * (k % 4) +: 16];
      end
      w = (k < 8) ? narrow_lo : narrow_hi;
      return {8'h00, w[8 * (k % 8) +: 8]};
    endfunction

    // Folds one character, shifts it into the window and compares the newest ones.
    function void fold_and_shift(char_t c);
      char_t lc;
      int unsigned n;
      int unsigned k;
      int i;
      logic hit;
      lc = c;
      if (c >= UPPER_A && c <= UPPER_Z) lc = c + CASE_OFFSET;
      for (i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = lc;
      if (seen < WINDOW_DEPTH) seen++;
      n = wide ? wide_len : narrow_len;
      if (n == 0 || n > WINDOW_DEPTH || n > PATTERN_SLOTS || seen < n) return;
      hit = 1'b1;
      for (k = 0; k < n; k++) begin
        if (win[n - 1 - k] != pattern_char(k)) hit = 1'b0;
      end
      if (hit) found = 1'b1;
    endfunction

    // Notes one accepted byte; the last byte of a file owes a verdict.
    function void take_byte(logic [7:0] b, logic eof);
      verdict_t v;
      case (head)
        HEAD_FIRST: begin
          first_hold = b;
          head = HEAD_SECOND;
          if (eof) fold_and_shift({8'h00, b});
        end
        HEAD_SECOND: begin
          head = HEAD_BODY;
          if (first_hold == MARK_FIRST && b == MARK_SECOND) begin
            wide = 1'b1;
          end else begin
            fold_and_shift({8'h00, first_hold});
            fold_and_shift({8'h00, b});
          end
        end
        default: begin
          if (wide) begin
            if (!odd_pair) begin
              low_hold = b;
              odd_pair = 1'b1;
            end else begin
              odd_pair = 1'b0;
              fold_and_shift({b, low_hold});
            end
          end else begin
            fold_and_shift({8'h00, b});
          end
        end
      endcase
      if (eof) begin
        v.text_found = found;
        v.was_wide = wide;
        verdicts_due = {verdicts_due, v};
        clear_file();
      end
    endfunction

    function void check_verdict(logic text_found, logic was_wide);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got text_found %0b was_wide %0b",
                 $time, text_found, was_wide);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      files_checked++;
      if (v.was_wide) wide_files++;
      if (v.text_found) hit_files++;
      if (text_found !== v.text_found) begin
        $display("%0t: text_found expected %0b, got %0b", $time, v.text_found, text_found);
        errors++;
      end
      if (was_wide !== v.was_wide) begin
        $display("%0t: was_wide expected %0b, got %0b", $time, v.was_wide, was_wide);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        text_found_o;
  logic        was_wide_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  match_tracker tracker = new();

  logic [7:0]  file_bytes [$];
  logic [7:0]  narrow_chars [16];
  char_t       wide_chars [16];
  int unsigned narrow_span;
  int unsigned wide_span;
  int unsigned cur_nplant;
  int unsigned cur_wplant;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic        quiet_sender = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned phases_run = 0;

  caseless_substring_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .text_found_o  (text_found_o),
    .was_wide_o    (was_wide_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d verdicts outstanding.",
               cycle_count, tracker.pending());
      $display("tb_caseless_substring_detector: done, errors");
      $finish;
    end
  end

  // Every accepted result transaction is checked against the oldest verdict owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_verdict(text_found_o, was_wide_o);
  end

  // Receiver back-pressure: changing styles, plus one long hold on request.
  stall_style_e stall_style = STALL_NONE;
  int unsigned  style_left = 0;
  int unsigned  hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(20, 150);
      end
      style_left = style_left - 1;
      case (stall_style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  // One register write transaction: setup phase, access phase, then an idle phase.
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Offers one byte, with random gaps between bursts, and waits for acceptance.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!quiet_sender && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) push_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Appends one byte to the file being built.
  function automatic void add_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endfunction

  // Lets the block drain completely before anything is reconfigured.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int unsigned plant_count(input logic [4:0] len);
    if (len > 16) return 16;
    return len;
  endfunction

  function automatic char_t vary_case(input char_t c);
    if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1) == 1) return c - CASE_OFFSET;
    return c;
  endfunction

  task automatic pick_patterns(input pattern_style_e style);
    int k;
    for (k = 0; k < 16; k++) begin
      if (style == PATTERN_RAW) begin
        narrow_chars[k] = 8'($urandom);
        wide_chars[k] = 16'($urandom);
      end else begin
        narrow_chars[k] = ($urandom_range(0, 7) != 0) ? 8'(LOWER_A + $urandom_range(0, 3))
                                                      : 8'($urandom_range(0, 255));
        wide_chars[k] = ($urandom_range(0, 7) != 0) ? 16'(LOWER_A + $urandom_range(0, 3))
                                                    : 16'($urandom_range(0, 16'hFFFF));
      end
    end
  endtask

  task automatic load_patterns(input logic [4:0] nlen, input logic [4:0] wlen);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] wp [4];
    int k;
    for (k = 0; k < 16; k++) begin
      if (k < 8) lo[8 * k +: 8] = narrow_chars[k];
      else hi[8 * (k - 8) +: 8] = narrow_chars[k];
      wp[k / 4][16 * (k % 4) +: 16] = wide_chars[k];
    end
    write_reg(REG_NARROW_LEN, {59'd0, nlen});
    write_reg(REG_NARROW_LO, lo);
    write_reg(REG_NARROW_HI, hi);
    write_reg(REG_WIDE_LEN, {59'd0, wlen});
    write_reg(REG_WIDE_0, wp[0]);
    write_reg(REG_WIDE_1, wp[1]);
    write_reg(REG_WIDE_2, wp[2]);
    write_reg(REG_WIDE_3, wp[3]);
    cur_nplant = plant_count(nlen);
    cur_wplant = plant_count(wlen);
    narrow_span = (cur_nplant == 0) ? 15 : cur_nplant - 1;
    wide_span = (cur_wplant == 0) ? 15 : cur_wplant - 1;
  endtask

  // Filler leans on pattern characters and a small alphabet to make near misses common.
  function automatic logic [7:0] narrow_filler();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'(vary_case({8'h00, narrow_chars[$urandom_range(0, narrow_span)]}));
    if (r < 8) return 8'(vary_case(16'(LOWER_A + $urandom_range(0, 3))));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic char_t wide_filler();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return vary_case(wide_chars[$urandom_range(0, wide_span)]);
    if (r < 8) return vary_case(16'(LOWER_A + $urandom_range(0, 3)));
    if (r < 9) return 16'($urandom_range(0, 16'hFFFF));
    return {8'h00, 8'($urandom_range(0, 255))};
  endfunction

  task automatic build_file(input file_kind_e kind);
    int n;
    int spot;
    int i;
    int k;
    char_t c;
    file_bytes.delete();
    case (kind)
      FILE_NARROW: begin
        n = $urandom_range(1, 40);
        spot = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n);
        for (i = 0; i <= n; i++) begin
          if (i == spot) begin
            for (k = 0; k < cur_nplant; k++)
              add_byte(8'(vary_case({8'h00, narrow_chars[k]})));
          end
          if (i < n) add_byte(narrow_filler());
        end
      end
      FILE_WIDE: begin
        add_byte(MARK_FIRST);
        add_byte(MARK_SECOND);
        n = $urandom_range(0, 20);
        spot = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n);
        for (i = 0; i <= n; i++) begin
          if (i == spot) begin
            for (k = 0; k < cur_wplant; k++) begin
              c = vary_case(wide_chars[k]);
              add_byte(c[7:0]);
              add_byte(c[15:8]);
            end
          end
          if (i < n) begin
            c = wide_filler();
            add_byte(c[7:0]);
            add_byte(c[15:8]);
          end
        end
        // Occasionally leave an unpaired byte at the end.
        if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(0, 255)));
      end
      FILE_NOISE: begin
        n = $urandom_range(1, 30);
        for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
        if (n >= 2 && $urandom_range(0, 3) == 0) begin
          file_bytes[0] = MARK_FIRST;
          file_bytes[1] = MARK_SECOND;
        end
      end
      default: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: add_byte(MARK_FIRST);
            1: add_byte(MARK_SECOND);
            2: add_byte(narrow_filler());
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    endcase
    if (file_bytes.size() == 0) add_byte(narrow_filler());
  endtask

  // Main sequence: directed files, then phases of random files under varied settings.
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned r;
    logic [4:0] nlen;
    logic [4:0] wlen;
    pattern_style_e style;
    file_kind_e kind;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset lengths are zero, so nothing can match.
    file_bytes = {8'h61};
    send_file();
    settle();

    // Single-character patterns make each head and folding case visible.
    pick_patterns(PATTERN_LETTERS);
    narrow_chars[0] = 8'h61;
    wide_chars[0] = LOWER_A;
    load_patterns(5'd1, 5'd1);
    file_bytes = {8'h41};
    send_file();
    file_bytes = {8'hFF, 8'hFE, 8'h41, 8'h00};
    send_file();
    file_bytes = {8'hFF, 8'hFE, 8'h61};
    send_file();
    file_bytes = {8'hFF, 8'h41};
    send_file();
    file_bytes = {8'hFF};
    send_file();
    file_bytes = {8'hFE, 8'hFF, 8'h00};
    send_file();
    file_bytes = {8'h5B, 8'h40, 8'h7A};
    send_file();
    file_bytes = {8'hFF, 8'hFE};
    send_file();
    settle();

    phase = 0;
    while (bytes_sent < ITEMS) begin
      style = (phase >= 6 && phase % 3 == 0) ? PATTERN_RAW : PATTERN_LETTERS;
      case (phase)
        0: begin nlen = 5'd16; wlen = 5'd16; end
        1: begin nlen = 5'd1;  wlen = 5'd1;  end
        2: begin nlen = 5'd0;  wlen = 5'd16; end
        3: begin nlen = 5'd17; wlen = 5'd31; end
        4: begin nlen = 5'd31; wlen = 5'd0;  end
        default: begin
          if (style == PATTERN_RAW) begin
            nlen = 5'($urandom_range(0, 31));
            wlen = 5'($urandom_range(0, 31));
          end else begin
            nlen = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 6));
            wlen = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 6));
          end
        end
      endcase
      pick_patterns(style);
      load_patterns(nlen, wlen);
      quiet_sender = (phase % 3 == 1);
      // Long receiver hold while the sender keeps offering bytes.
      if (phase == 5) hold_request <= 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r < 4) kind = FILE_NARROW;
        else if (r < 7) kind = FILE_WIDE;
        else if (r < 8) kind = FILE_NOISE;
        else kind = FILE_TINY;
        build_file(kind);
        send_file();
      end
      settle();
      phase++;
      phases_run = phase;
    end

    $display("Covered %0d bytes in %0d files (%0d wide, %0d with a hit).",
             bytes_sent, tracker.files_checked, tracker.wide_files, tracker.hit_files);
    $display("Register settings run: %0d random phases after the directed files.", phases_run);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_caseless_substring_detector: done, clean");
    end else begin
      $display("tb_caseless_substring_detector: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/csd_pkg.sv
rtl/csd_cell.sv
rtl/caseless_substring_detector.sv
rtl/csd_checker.sv
tb/tb_caseless_substring_detector.sv
